// File: hw/rtl/citt_pkg.sv
// Shared types, codes and defaults for the connection idle timeout table.
// Used by the entry cell, the remainder unit and the top level.
package citt_pkg;

    localparam int CONNECTIONS_DEF = 64;
    localparam int NOW_W = 32;
    localparam int CFG_W = 16;
    localparam int CONN_W = 6;

    localparam logic [1:0] ST_FREE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_ACTIVE = 2'd2;
    localparam logic [1:0] ST_CLOSING = 2'd3;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_RECEIVE = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;
    localparam logic [1:0] KIND_TICK = 2'd3;

    localparam logic [1:0] ERR_OK = 2'd0;
    localparam logic [1:0] ERR_USED = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN = 2'd2;

    localparam logic [1:0] CFG_FIRST_MSG = 2'd0;
    localparam logic [1:0] CFG_HEARTBEAT = 2'd1;
    localparam logic [1:0] CFG_GRANULE = 2'd2;

    localparam logic [CFG_W-1:0] FIRST_MSG_RST = 16'd5;
    localparam logic [CFG_W-1:0] HEARTBEAT_RST = 16'd60;
    localparam logic [CFG_W-1:0] GRANULE_RST = 16'd10;

    typedef struct packed {
        logic [1:0]       status;
        logic [NOW_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [NOW_W-1:0] dividend;
        logic [CFG_W-1:0] divisor;
    } t_rem_req;

endpackage

// File: hw/rtl/citt_cell.sv
// One entry cell of the rotating table: holds status and stamp of one slot.
// Depends on citt_pkg for the entry type and status codes.
module citt_cell import citt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_entry,
    output t_entry o_entry
);

    logic [1:0]       r_status;
    logic [NOW_W-1:0] r_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_FREE;
        end else if (i_shift) begin
            r_status <= i_entry.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_stamp <= i_entry.stamp;
        end
    end

    assign o_entry = '{status: r_status, stamp: r_stamp};

endmodule

// File: hw/rtl/citt_rem.sv
// Bit-serial restoring remainder unit: dividend modulo a 16-bit divisor.
// Depends on citt_pkg for widths and the request struct.
module citt_rem import citt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_rem_req         i_req,
    output logic             o_done,
    output logic [CFG_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NOW_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NOW_W-1:0] r_shf;
    logic [CFG_W-1:0] r_div;
    logic [CFG_W-1:0] r_rem;
    logic             r_done;
    logic [CFG_W:0]   n_trial;

    always_comb begin
        n_trial = {r_rem, r_shf[NOW_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NOW_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_shf <= i_req.dividend;
            r_div <= (i_req.divisor == '0) ? CFG_W'(1) : i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_shf <= {r_shf[NOW_W-2:0], 1'b0};
            if (n_trial >= {1'b0, r_div}) begin
                r_rem <= CFG_W'(n_trial - {1'b0, r_div});
            end else begin
                r_rem <= n_trial[CFG_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: hw/rtl/connection_idle_timeout_table.sv
// Connection idle timeout table. One request at a time: a request passes
// through the 32-step remainder unit that rounds the time down to the
// granule and then through one full turn of the ring of CONNECTIONS entry
// cells, which passes each entry past the head once per request. A tick
// reports expired entries in ascending order; the scan holds while the
// output register is full. No clearing pass after reset.
module connection_idle_timeout_table import citt_pkg::*; #(
    parameter int CONNECTIONS = CONNECTIONS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_kind,
    input  logic [CONN_W-1:0] i_conn,
    input  logic [NOW_W-1:0]  i_now,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CONN_W-1:0] o_expired_conn,
    output logic              o_expired_valid,
    output logic [1:0]        o_error_code,
    output logic              o_last
);

    localparam int ID_W = $clog2(CONNECTIONS);
    localparam int W = (ID_W > CONN_W) ? ID_W : CONN_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN = 2'd3;

    logic [CFG_W-1:0]  r_fmt, r_hbt, r_gran;
    logic [1:0]        r_state;
    logic [1:0]        r_kind;
    logic [W-1:0]      r_conn;
    logic [NOW_W-1:0]  r_now, r_rnow;
    logic [ID_W-1:0]   r_idx;
    logic [1:0]        r_err;
    logic              r_pend_v;
    logic [CONN_W-1:0] r_pend;
    logic              r_ov;
    logic [CONN_W-1:0] r_oc;
    logic              r_oev, r_olast;
    logic [1:0]        r_oerr;

    t_entry            w_ent [CONNECTIONS];
    t_entry            n_head;
    t_rem_req          w_req;
    logic              w_done;
    logic [CFG_W-1:0]  w_rem;
    logic              w_accept, w_out_free, w_hit, w_match, w_adv, w_emit, w_shift;
    logic [W-1:0]      w_idx_x;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_ov || !i_out_stall;
    assign w_idx_x    = W'(r_idx);
    assign w_match    = (r_kind != KIND_TICK) && (w_idx_x == r_conn);

    assign w_req = '{start: w_accept, dividend: i_now, divisor: r_gran};

    citt_rem u_rem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_done),
        .o_rem  (w_rem)
    );

    always_comb begin
        w_hit = 1'b0;
        if (r_kind == KIND_TICK) begin
            if (w_ent[0].status == ST_WAIT) begin
                w_hit = ({1'b0, w_ent[0].stamp} + (NOW_W+1)'(r_fmt)) < {1'b0, r_now};
            end else if (w_ent[0].status == ST_ACTIVE) begin
                w_hit = ({1'b0, w_ent[0].stamp} + (NOW_W+1)'(r_hbt)) < {1'b0, r_rnow};
            end
        end
    end

    assign w_emit  = w_hit && r_pend_v;
    assign w_adv   = !w_emit || w_out_free;
    assign w_shift = (r_state == S_SCAN) && w_adv;

    always_comb begin
        n_head = w_ent[0];
        if (w_hit) begin
            n_head.status = ST_CLOSING;
        end else if (w_match) begin
            case (r_kind)
                KIND_ACCEPT: begin
                    if (w_ent[0].status == ST_FREE) begin
                        n_head.status = ST_WAIT;
                        n_head.stamp  = r_now;
                    end
                end
                KIND_RECEIVE: begin
                    if (w_ent[0].status == ST_WAIT || w_ent[0].status == ST_ACTIVE) begin
                        n_head.status = ST_ACTIVE;
                        n_head.stamp  = r_rnow;
                    end
                end
                default: begin
                    n_head.status = ST_FREE;
                end
            endcase
        end
    end

    for (genvar j = 0; j < CONNECTIONS; j++) begin : g_cell
        citt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_shift(w_shift),
            .i_entry((j == CONNECTIONS - 1) ? n_head : w_ent[(j + 1) % CONNECTIONS]),
            .o_entry(w_ent[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= FIRST_MSG_RST;
            r_hbt  <= HEARTBEAT_RST;
            r_gran <= GRANULE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_MSG: r_fmt  <= i_cfg_data;
                CFG_HEARTBEAT: r_hbt  <= i_cfg_data;
                CFG_GRANULE:   r_gran <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((w_shift && w_emit) || (r_state == S_FIN && w_out_free)) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
            r_idx    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        r_state <= S_SCAN;
                        r_idx   <= '0;
                    end
                end
                S_SCAN: begin
                    if (w_adv) begin
                        if (w_hit) begin
                            r_pend_v <= 1'b1;
                        end
                        r_idx <= r_idx + ID_W'(1);
                        if (r_idx == ID_W'(CONNECTIONS - 1)) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                default: begin
                    if (w_out_free) begin
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_kind;
            r_conn <= W'(i_conn);
            r_now  <= i_now;
            r_err  <= ERR_UNKNOWN;
        end
        if (r_state == S_DIV && w_done) begin
            r_rnow <= r_now - NOW_W'(w_rem);
        end
        if (w_shift) begin
            if (w_hit) begin
                r_pend <= w_idx_x[CONN_W-1:0];
            end
            if (w_emit) begin
                r_oc    <= r_pend;
                r_oev   <= 1'b1;
                r_oerr  <= ERR_OK;
                r_olast <= 1'b0;
            end
            if (w_match) begin
                case (r_kind)
                    KIND_ACCEPT: r_err <= (w_ent[0].status == ST_FREE) ? ERR_OK : ERR_USED;
                    default:     r_err <= (w_ent[0].status == ST_FREE) ? ERR_UNKNOWN : ERR_OK;
                endcase
            end
        end
        if (r_state == S_FIN && w_out_free) begin
            r_olast <= 1'b1;
            if (r_kind == KIND_TICK) begin
                r_oc   <= r_pend_v ? r_pend : '0;
                r_oev  <= r_pend_v;
                r_oerr <= ERR_OK;
            end else begin
                r_oc   <= '0;
                r_oev  <= 1'b0;
                r_oerr <= r_err;
            end
        end
    end

    assign o_out_valid     = r_ov;
    assign o_expired_conn  = r_oc;
    assign o_expired_valid = r_oev;
    assign o_error_code    = r_oerr;
    assign o_last          = r_olast;

`ifndef NO_ASSERTIONS
    a_accept_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DIV))
        else $error("accepted request did not start rounding");
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pending expiry left over in idle");
    a_scan_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !w_adv) |=> $stable(r_idx))
        else $error("scan advanced while output was blocked");
`endif

endmodule

// File: verif/connection_idle_timeout_table_test.sv
// Self-checking test of connection_idle_timeout_table: a scoreboard class tracks the
// connection table, predicts each request's results and checks the output stream.
// Depends on citt_pkg and the connection_idle_timeout_table top level.
`timescale 1ns / 100ps

import citt_pkg::*;

typedef struct packed {
    logic [CONN_W-1:0] conn;
    logic              exp_valid;
    logic [1:0]        err;
    logic              last;
} t_timeout_result;

class timeout_scoreboard;
    logic [1:0]       status [64];
    logic [NOW_W-1:0] stamp [64];
    logic [CFG_W-1:0] first_msg;
    logic [CFG_W-1:0] heartbeat;
    logic [CFG_W-1:0] granule;
    t_timeout_result  pending [$];
    int               errors;

    function new();
        first_msg = FIRST_MSG_RST;
        heartbeat = HEARTBEAT_RST;
        granule = GRANULE_RST;
        errors = 0;
        foreach (status[i]) begin
            status[i] = ST_FREE;
            stamp[i] = '0;
        end
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        if (idx == CFG_FIRST_MSG) first_msg = val;
        else if (idx == CFG_HEARTBEAT) heartbeat = val;
        else if (idx == CFG_GRANULE) granule = val;
    endfunction

    function logic [NOW_W-1:0] floor_time(logic [NOW_W-1:0] t);
        logic [NOW_W-1:0] g;
        g = (granule == '0) ? NOW_W'(1) : NOW_W'(granule);
        return t - (t % g);
    endfunction

    function void note_request(logic [1:0] kind, logic [CONN_W-1:0] conn,
                               logic [NOW_W-1:0] now);
        t_timeout_result r;
        logic [NOW_W:0] lhs;
        logic [NOW_W-1:0] rnow;
        int n;
        bit hit;
        r = '0;
        r.last = 1'b1;
        if (kind == KIND_TICK) begin
            rnow = floor_time(now);
            n = 0;
            for (int i = 0; i < 64; i++) begin
                hit = 0;
                if (status[i] == ST_WAIT) begin
                    lhs = {1'b0, stamp[i]} + (NOW_W+1)'(first_msg);
                    hit = lhs < {1'b0, now};
                end else if (status[i] == ST_ACTIVE) begin
                    lhs = {1'b0, stamp[i]} + (NOW_W+1)'(heartbeat);
                    hit = lhs < {1'b0, rnow};
                end
                if (hit) begin
                    status[i] = ST_CLOSING;
                    r.conn = CONN_W'(i);
                    r.exp_valid = 1'b1;
                    r.last = 1'b0;
                    pending.push_back(r);
                    n++;
                end
            end
            if (n == 0) begin
                r = '0;
                r.last = 1'b1;
                pending.push_back(r);
            end else begin
                pending[$].last = 1'b1;
            end
            return;
        end
        if (kind == KIND_ACCEPT) begin
            if (status[conn] != ST_FREE) begin
                r.err = ERR_USED;
            end else begin
                status[conn] = ST_WAIT;
                stamp[conn] = now;
            end
        end else if (kind == KIND_RECEIVE) begin
            if (status[conn] == ST_FREE) begin
                r.err = ERR_UNKNOWN;
            end else if (status[conn] != ST_CLOSING) begin
                status[conn] = ST_ACTIVE;
                stamp[conn] = floor_time(now);
            end
        end else begin
            if (status[conn] == ST_FREE) r.err = ERR_UNKNOWN;
            else status[conn] = ST_FREE;
        end
        pending.push_back(r);
    endfunction

    task check_result(t_timeout_result got);
        t_timeout_result want;
        if (pending.size() == 0) begin
            report_mismatch("unexpected result", '0, got);
            return;
        end
        want = pending.pop_front();
        if (got !== want) report_mismatch("field mismatch", want, got);
    endtask

    task report_mismatch(string what, t_timeout_result want, t_timeout_result got);
        $display("MISMATCH %s: want conn=%0d v=%0b err=%0d last=%0b %s%0d v=%0b err=%0d last=%0b",
                 what, want.conn, want.exp_valid, want.err, want.last, "got conn=",
                 got.conn, got.exp_valid, got.err, got.last);
        errors++;
    endtask
endclass

module connection_idle_timeout_table_test;
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_idx = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_kind = '0;
    logic [CONN_W-1:0] i_conn = '0;
    logic [NOW_W-1:0]  i_now = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [CONN_W-1:0] o_expired_conn;
    logic              o_expired_valid;
    logic [1:0]        o_error_code;
    logic              o_last;

    timeout_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_off = 0;
    int  cycle_count = 0;
    logic [NOW_W-1:0] clock_now = 0;

    localparam int CYCLE_LIMIT = 3000000;

    connection_idle_timeout_table dut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_expired_conn, o_expired_valid, o_error_code, o_last});
        i_out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_request(logic [1:0] kind, logic [CONN_W-1:0] conn,
                                logic [NOW_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_conn <= conn;
        i_now <= now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(kind, conn, now);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic random_phase(int count);
        int r;
        logic [1:0] kind;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            clock_now = clock_now + $urandom_range(4);
            if (r < 3) clock_now = $urandom;
            if (r < 30) kind = KIND_ACCEPT;
            else if (r < 60) kind = KIND_RECEIVE;
            else if (r < 80) kind = KIND_CLOSE;
            else kind = KIND_TICK;
            send_request(kind, CONN_W'($urandom_range(63)), clock_now);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(KIND_TICK, 0, 0);
        send_request(KIND_RECEIVE, 5, 100);
        send_request(KIND_CLOSE, 63, 100);
        send_request(KIND_ACCEPT, 0, 100);
        send_request(KIND_ACCEPT, 0, 101);
        send_request(KIND_ACCEPT, 63, 32'hFFFF_FFF0);
        send_request(KIND_ACCEPT, 7, 100);
        send_request(KIND_RECEIVE, 7, 107);
        send_request(KIND_TICK, 0, 105);
        send_request(KIND_TICK, 0, 106);
        send_request(KIND_RECEIVE, 0, 120);
        send_request(KIND_CLOSE, 0, 120);
        send_request(KIND_TICK, 0, 171);
        send_request(KIND_TICK, 0, 32'hFFFF_FFFF);
        send_request(KIND_ACCEPT, 7, 200);
        send_request(KIND_CLOSE, 7, 200);
        send_request(KIND_CLOSE, 63, 200);
        send_request(KIND_CLOSE, 7, 200);

        write_reg(CFG_GRANULE, 0);
        write_reg(CFG_FIRST_MSG, 16'hFFFF);
        write_reg(CFG_HEARTBEAT, 0);
        send_request(KIND_ACCEPT, 42, 32'hFFFF_FFFE);
        send_request(KIND_RECEIVE, 21, 32'hAAAA_5555);
        send_request(KIND_ACCEPT, 21, 32'h5555_AAAA);
        send_request(KIND_RECEIVE, 21, 32'h5555_AAAB);
        send_request(KIND_TICK, 0, 32'hFFFF_FFFF);

        send_idle_pct = 19;
        recv_idle_pct = 82;
        random_phase(100);
        write_reg(CFG_FIRST_MSG, 0);
        write_reg(CFG_HEARTBEAT, 16'hFFFF);
        write_reg(CFG_GRANULE, 16'hFFFF);
        send_idle_pct = 82;
        recv_idle_pct = 19;
        random_phase(100);
        write_reg(CFG_FIRST_MSG, 3);
        write_reg(CFG_HEARTBEAT, 8);
        write_reg(CFG_GRANULE, 1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            random_phase(100);
        join

        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/citt_pkg.sv
hw/rtl/citt_cell.sv
hw/rtl/citt_rem.sv
hw/rtl/connection_idle_timeout_table.sv
verif/connection_idle_timeout_table_test.sv
